// ===== hw/rtl/isw_pkg.sv =====
package isw_pkg;

    localparam int CHANNELS   = 6;
    localparam int CH_W       = 16;
    localparam int SAMPLE_W   = CHANNELS * CH_W;
    localparam int SEQ_W      = 16;
    localparam int EXT_W      = 32;
    localparam int POS_W      = 6;
    localparam int HOP_W      = 8;
    localparam int WINDOW_DEF = 64;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = SAMPLE_W + SEQ_W;
    localparam int OUT_DATA_W = ((SAMPLE_W + POS_W + EXT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - (SAMPLE_W + POS_W + EXT_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [HOP_W-1:0] HOP_RESET      = 8'd64;
    localparam logic             REG_HOP_LENGTH = 1'b0;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic fire;
        logic out_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/imu_sliding_window_framer_top.sv =====
// Channel   Kind          Carries
// apb       config port   hop_length at byte address 0
// s_*       stream in     sample transactions and restart commands
// m_*       stream out    window transactions, oldest sample first
//
// The input is ready only while idle. A window readout goes through a read
// state, then a load and a hold state per output transaction, as the sample
// store has a registered read port and there is a single output register.
// Reset is asynchronous, active low; the store keeps no reset and needs no clear.
// Output stalls hold the output register; the input stays stalled until the last
// transaction of a window is taken.
module imu_sliding_window_framer_top #(
    parameter int WINDOW = isw_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [isw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [isw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, sample_seq
    input  logic [isw_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y, out_gyro_z,
    // position, window_end_seq, zero pad
    output logic [isw_pkg::OUT_DATA_W-1:0]    m_tdata,
    // last_of_window
    output logic                              m_tlast
);

    logic [isw_pkg::HOP_W-1:0] hop_length_reg, hop_length_next;
    logic                      cfg_write;
    isw_pkg::dp_cmd_t          cmd;
    isw_pkg::dp_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == isw_pkg::REG_HOP_LENGTH);

    assign hop_length_next = cfg_write ? pwdata[isw_pkg::HOP_W-1:0] : hop_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_length_reg <= isw_pkg::HOP_RESET;
        end
        else
        begin
            hop_length_reg <= hop_length_next;
        end
    end

    assign prdata = (paddr[2] == isw_pkg::REG_HOP_LENGTH)
                    ? {{(isw_pkg::APB_DATA_W-isw_pkg::HOP_W){1'b0}}, hop_length_reg}
                    : '0;

    isw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    isw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .hop_length (hop_length_reg),
        .in_cmd     (s_tuser[0]),
        .in_data    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a window transaction is pending");

    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
        (m_tdata[isw_pkg::SAMPLE_W +: isw_pkg::POS_W] == isw_pkg::POS_W'(WINDOW - 1)))
        else $error("last flag on a transaction that is not the newest sample");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not ready after the window was delivered");
`endif

endmodule

// ===== hw/rtl/isw_ram.sv =====
module isw_ram #(
    parameter int WIDTH = isw_pkg::SAMPLE_W,
    parameter int DEPTH = isw_pkg::WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/isw_ctrl.sv =====
module isw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  m_tready,
    input  isw_pkg::dp_status_t   status,
    output isw_pkg::dp_cmd_t      cmd
);

    isw_pkg::state_t state_reg;
    isw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isw_pkg::ST_IDLE:
            begin
                if (s_tvalid && status.fire)
                begin
                    state_next = isw_pkg::ST_READ;
                end
            end
            isw_pkg::ST_READ:
            begin
                state_next = isw_pkg::ST_LOAD;
            end
            isw_pkg::ST_LOAD:
            begin
                state_next = isw_pkg::ST_HOLD;
            end
            isw_pkg::ST_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = status.out_last ? isw_pkg::ST_IDLE : isw_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = isw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            isw_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            isw_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            isw_pkg::ST_LOAD:
            begin
                cmd.load_out = 1'b1;
            end
            isw_pkg::ST_HOLD:
            begin
                // fetch the next entry while the current one is taken
                cmd.rd_issue = m_tready && !status.out_last;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/isw_dp.sv =====
module isw_dp #(
    parameter int WINDOW = isw_pkg::WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  isw_pkg::dp_cmd_t                 cmd,
    output isw_pkg::dp_status_t              status,
    input  logic [isw_pkg::HOP_W-1:0]        hop_length,
    input  logic                             in_cmd,
    input  logic [isw_pkg::IN_DATA_W-1:0]    in_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [isw_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

    logic [PTR_W-1:0]                  wp_reg, wp_next;
    logic [CNT_W-1:0]                  fill_reg, fill_next;
    logic [isw_pkg::HOP_W-1:0]         hop_reg, hop_next;
    logic                              seen_reg, seen_next;
    logic [isw_pkg::SEQ_W-1:0]         prev_reg, prev_next;
    logic [isw_pkg::EXT_W-1:0]         ext_reg, ext_next;
    logic                              out_valid_reg, out_valid_next;
    logic [PTR_W-1:0]                  rd_addr_reg, rd_addr_next;
    logic [PTR_W-1:0]                  rd_pos_reg, rd_pos_next;
    logic [isw_pkg::SAMPLE_W-1:0]      out_data_reg, out_data_next;
    logic [PTR_W-1:0]                  out_pos_reg, out_pos_next;
    logic                              out_last_reg, out_last_next;

    logic                              is_restart;
    logic                              sample_we;
    logic                              fire;
    logic [isw_pkg::SEQ_W-1:0]         seq_in;
    logic [isw_pkg::SEQ_W-1:0]         seq_diff;
    logic [isw_pkg::SAMPLE_W-1:0]      sample;
    logic [isw_pkg::SAMPLE_W-1:0]      ram_rdata;
    logic [PTR_W-1:0]                  wp_inc;
    logic [PTR_W-1:0]                  rd_addr_inc;
    logic [CNT_W-1:0]                  fill_inc;
    logic [isw_pkg::HOP_W-1:0]         hop_inc;
    logic [isw_pkg::EXT_W-1:0]         ext_inc;

    assign is_restart = (in_cmd == isw_pkg::CMD_RESTART);
    assign seq_in     = in_data[isw_pkg::IN_DATA_W-1 -: isw_pkg::SEQ_W];
    assign sample     = in_data[isw_pkg::SAMPLE_W-1:0];
    assign sample_we  = cmd.accept && !is_restart;

    assign wp_inc      = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rd_addr_inc = (rd_addr_reg == PTR_LAST) ? '0 : rd_addr_reg + 1'b1;
    assign fill_inc    = (fill_reg == CNT_FULL) ? fill_reg : fill_reg + 1'b1;
    assign hop_inc     = (hop_reg < hop_length) ? hop_reg + 1'b1 : hop_reg;
    assign seq_diff    = seq_in - prev_reg;
    assign ext_inc     = seen_reg ? ext_reg + {{(isw_pkg::EXT_W-isw_pkg::SEQ_W){1'b0}}, seq_diff}
                                  : {{(isw_pkg::EXT_W-isw_pkg::SEQ_W){1'b0}}, seq_in};

    // window is due once the ring is full and the hop count has reached hop_length
    assign fire = !is_restart && (fill_inc == CNT_FULL) && !(hop_inc < hop_length);

    assign status.fire     = fire;
    assign status.out_last = out_last_reg;

    isw_ram #(
        .WIDTH (isw_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (sample_we),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (cmd.rd_issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        hop_next       = hop_reg;
        seen_next      = seen_reg;
        prev_next      = prev_reg;
        ext_next       = ext_reg;
        rd_addr_next   = rd_addr_reg;
        rd_pos_next    = rd_pos_reg;
        out_data_next  = out_data_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept)
        begin
            if (is_restart)
            begin
                wp_next   = '0;
                fill_next = '0;
                hop_next  = '0;
                seen_next = 1'b0;
                prev_next = '0;
                ext_next  = '0;
            end
            else
            begin
                wp_next   = wp_inc;
                fill_next = fill_inc;
                hop_next  = fire ? '0 : hop_inc;
                seen_next = 1'b1;
                prev_next = seq_in;
                ext_next  = ext_inc;
                if (fire)
                begin
                    // oldest entry sits right after the one just written
                    rd_addr_next = wp_inc;
                    rd_pos_next  = '0;
                end
            end
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_out)
        begin
            out_data_next  = ram_rdata;
            out_pos_next   = rd_pos_reg;
            out_last_next  = (rd_pos_reg == PTR_LAST);
            out_valid_next = 1'b1;
            rd_addr_next   = rd_addr_inc;
            rd_pos_next    = rd_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            hop_reg       <= '0;
            seen_reg      <= 1'b0;
            prev_reg      <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            hop_reg       <= hop_next;
            seen_reg      <= seen_next;
            prev_reg      <= prev_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        rd_pos_reg   <= rd_pos_next;
        out_data_reg <= out_data_next;
        out_pos_reg  <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{isw_pkg::OUT_PAD_W{1'b0}}, ext_reg,
                       isw_pkg::POS_W'(out_pos_reg), out_data_reg};

endmodule
